// ===== design/tlpc_pkg.sv =====
// ----------------------------------------------------------------------------
// TTL location cache package
// Shared types, operation and status codes, and hash constants.
// ----------------------------------------------------------------------------
package tlpc_pkg;

    // Operation codes carried by an input transfer.
    typedef enum logic [1:0] {
        OP_LOOKUP     = 2'd0,
        OP_INSERT_POS = 2'd1,
        OP_INSERT_NEG = 2'd2,
        OP_INVALIDATE = 2'd3
    } op_t;

    // Result status codes.
    localparam logic [1:0] ST_MISS = 2'd0;
    localparam logic [1:0] ST_POS  = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;

    // 32-bit FNV-1a constants.
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [30:0] POS_TTL_RESET = 31'd30000;
    localparam logic [30:0] NEG_TTL_RESET = 31'd0;

    // Configuration register indexes.
    localparam logic CFG_POS_TTL = 1'b0;
    localparam logic CFG_NEG_TTL = 1'b1;

    // One request as it moves from the front end to the probe engine.
    typedef struct packed {
        op_t         op;
        logic [63:0] key;
        logic [31:0] now;
        logic [31:0] host;
        logic [15:0] port;
    } item_t;

    // One table entry.
    typedef struct packed {
        logic        used;
        logic [63:0] key;
        logic [31:0] host;
        logic [15:0] port;
        logic [31:0] expiry;
    } entry_t;

    // An entry is expired when the signed distance to its expiry is not positive.
    function automatic logic is_expired(input logic [31:0] now, input logic [31:0] expiry);
        logic [31:0] d;
        d = expiry - now;
        return (d == 32'd0) || d[31];
    endfunction

endpackage

// ===== design/tlpc_front.sv =====
// ----------------------------------------------------------------------------
// TTL location cache front end
// Accepts requests, hashes the key with FNV-1a one byte per cycle and
// reduces the hash to a home slot, then hands the request to the queue.
// ----------------------------------------------------------------------------
module tlpc_front #(
    parameter int SLOT_COUNT = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          enable,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tlpc_pkg::item_t               in_item,
    output logic                          push,
    input  logic                          full,
    output tlpc_pkg::item_t               push_item,
    output logic [$clog2(SLOT_COUNT)-1:0] push_home
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam bit POW2 = ((1 << IW) == SLOT_COUNT);
    localparam logic [IW:0] SLOTS_W = (IW + 1)'(SLOT_COUNT);

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_MOD,
        F_PUSH
    } fstate_t;

    fstate_t         state_reg;
    tlpc_pkg::item_t item_reg;
    logic [31:0]     hash_reg;
    logic [4:0]      step_reg;
    logic [IW:0]     rem_reg;

    logic [7:0]      key_byte;
    logic [IW+1:0]   rem_shift;
    logic [IW+1:0]   rem_sub;

    // Byte of the key taken in this hash step, lowest first.
    assign key_byte  = item_reg.key[{step_reg[2:0], 3'b000} +: 8];
    // One restoring division step for the home slot remainder.
    assign rem_shift = {rem_reg, hash_reg[5'd31 - step_reg]};
    assign rem_sub   = rem_shift - {1'b0, SLOTS_W};

    assign in_ready  = (state_reg == F_IDLE) && enable;
    assign push      = (state_reg == F_PUSH) && !full;
    assign push_item = item_reg;
    assign push_home = POW2 ? hash_reg[IW-1:0] : rem_reg[IW-1:0];

    // Front end sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (in_valid && enable) begin
                        item_reg  <= in_item;
                        hash_reg  <= tlpc_pkg::FNV_BASIS;
                        step_reg  <= '0;
                        state_reg <= F_HASH;
                    end
                end
                F_HASH: begin
                    hash_reg <= (hash_reg ^ {24'd0, key_byte}) * tlpc_pkg::FNV_PRIME;
                    if (step_reg[2:0] == 3'd7) begin
                        step_reg  <= '0;
                        rem_reg   <= '0;
                        state_reg <= POW2 ? F_PUSH : F_MOD;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                F_MOD: begin
                    if (rem_sub[IW+1]) begin
                        rem_reg <= rem_shift[IW:0];
                    end else begin
                        rem_reg <= rem_sub[IW:0];
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31) begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/tlpc_queue.sv =====
// ----------------------------------------------------------------------------
// TTL location cache request queue
// Two-entry queue that decouples the front end from the probe engine.
// ----------------------------------------------------------------------------
module tlpc_queue #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output logic [DW-1:0] pop_data
);

    logic [DW-1:0] data_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = data_reg[rd_ptr_reg];

    // Storage and pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                data_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg           <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== design/tlpc_back.sv =====
// ----------------------------------------------------------------------------
// TTL location cache probe engine
// Owns the slot memory, clears it after reset, walks the probe sequence for
// each request and holds the result register.
// ----------------------------------------------------------------------------
module tlpc_back #(
    parameter int SLOT_COUNT = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [30:0]                   pos_ttl,
    input  logic [30:0]                   neg_ttl,
    output logic                          ready,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  tlpc_pkg::item_t               q_item,
    input  logic [$clog2(SLOT_COUNT)-1:0] q_home,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_status,
    output logic [31:0]                   out_host,
    output logic [15:0]                   out_port
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_EVAL,
        B_DONE
    } bstate_t;

    bstate_t          state_reg;
    tlpc_pkg::item_t  item_reg;
    logic [IW-1:0]    home_reg;
    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    cnt_reg;
    logic [1:0]       status_reg;
    logic [31:0]      host_reg;
    logic [15:0]      port_reg;
    logic             wr_en_reg;
    logic [IW-1:0]    wr_addr_reg;
    tlpc_pkg::entry_t wr_data_reg;
    tlpc_pkg::entry_t rd_data_reg;
    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [31:0]      out_host_reg;
    logic [15:0]      out_port_reg;

    tlpc_pkg::entry_t mem [SLOT_COUNT];

    logic             expired;
    logic             match;
    logic             skip_item;
    logic [30:0]      ttl;
    tlpc_pkg::entry_t new_entry;

    assign ready      = (state_reg != B_CLEAR);
    assign q_pop      = (state_reg == B_IDLE) && q_valid;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_host   = out_host_reg;
    assign out_port   = out_port_reg;

    assign expired   = tlpc_pkg::is_expired(item_reg.now, rd_data_reg.expiry);
    assign match     = (rd_data_reg.key == item_reg.key);
    // A positive insert with host zero or a negative insert with no TTL is dropped.
    assign skip_item = ((q_item.op == tlpc_pkg::OP_INSERT_POS) && (q_item.host == 32'd0))
                    || ((q_item.op == tlpc_pkg::OP_INSERT_NEG) && (neg_ttl == 31'd0));
    assign ttl       = (item_reg.op == tlpc_pkg::OP_INSERT_POS) ? pos_ttl : neg_ttl;

    // Entry written by an insert; negative entries carry host and port zero.
    always_comb begin
        new_entry.used   = 1'b1;
        new_entry.key    = item_reg.key;
        new_entry.host   = (item_reg.op == tlpc_pkg::OP_INSERT_POS) ? item_reg.host : 32'd0;
        new_entry.port   = (item_reg.op == tlpc_pkg::OP_INSERT_POS) ? item_reg.port : 16'd0;
        new_entry.expiry = item_reg.now + {1'b0, ttl};
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en_reg) begin
            mem[wr_addr_reg] <= wr_data_reg;
        end
        rd_data_reg <= mem[idx_reg];
    end

    // Probe sequencer, memory write stage and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            wr_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wr_en_reg <= 1'b0;
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR: begin
                    wr_en_reg   <= 1'b1;
                    wr_addr_reg <= cnt_reg;
                    wr_data_reg <= '0;
                    cnt_reg     <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST) begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (q_valid) begin
                        item_reg   <= q_item;
                        home_reg   <= q_home;
                        idx_reg    <= q_home;
                        cnt_reg    <= '0;
                        status_reg <= tlpc_pkg::ST_MISS;
                        host_reg   <= '0;
                        port_reg   <= '0;
                        state_reg  <= skip_item ? B_DONE : B_READ;
                    end
                end
                B_READ: begin
                    state_reg <= B_EVAL;
                end
                B_EVAL: begin
                    state_reg <= B_DONE;
                    case (item_reg.op)
                        tlpc_pkg::OP_LOOKUP: begin
                            if (!rd_data_reg.used) begin
                                state_reg <= B_DONE;
                            end else if (!expired && match) begin
                                if (rd_data_reg.host == 32'd0) begin
                                    status_reg <= tlpc_pkg::ST_NEG;
                                end else begin
                                    status_reg <= tlpc_pkg::ST_POS;
                                    host_reg   <= rd_data_reg.host;
                                    port_reg   <= rd_data_reg.port;
                                end
                            end else if (cnt_reg != LAST) begin
                                state_reg <= B_READ;
                            end
                        end
                        tlpc_pkg::OP_INVALIDATE: begin
                            if (!rd_data_reg.used) begin
                                state_reg <= B_DONE;
                            end else if (match) begin
                                wr_en_reg   <= 1'b1;
                                wr_addr_reg <= idx_reg;
                                wr_data_reg <= {rd_data_reg.used, rd_data_reg.key,
                                                rd_data_reg.host, rd_data_reg.port,
                                                item_reg.now};
                            end else if (cnt_reg != LAST) begin
                                state_reg <= B_READ;
                            end
                        end
                        default: begin
                            // Inserts claim a free, expired or same-key slot, else home.
                            if (!rd_data_reg.used || expired || match) begin
                                wr_en_reg   <= 1'b1;
                                wr_addr_reg <= idx_reg;
                                wr_data_reg <= new_entry;
                            end else if (cnt_reg != LAST) begin
                                state_reg <= B_READ;
                            end else begin
                                wr_en_reg   <= 1'b1;
                                wr_addr_reg <= home_reg;
                                wr_data_reg <= new_entry;
                            end
                        end
                    endcase
                    // Advance to the next slot, wrapping at the end of the table.
                    idx_reg <= (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                B_DONE: begin
                    if (!out_valid_reg || out_ready) begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_host_reg   <= host_reg;
                        out_port_reg   <= port_reg;
                        state_reg      <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/ttl_linear_probe_location_cache_top.sv =====
// ----------------------------------------------------------------------------
// TTL location cache top level
// Open-addressed cache with linear probing and per-entry expiry times.
//
//   Channel   Direction  Contents
//   s_axis    in         operation, key, now, host_in, port_in
//   m_axis    out        status, host_out, port_out (one per request)
//   cfg       in         positive_ttl (index 0), negative_ttl (index 1)
//
// The front end takes a transfer, hashes its key byte by byte (followed by
// remainder steps when SLOT_COUNT is not a power of two) and pushes it once
// the queue has room, and takes no new transfer until that push is done. The
// probe engine reads and then evaluates each probed slot on its single memory
// read port, and also pops the request and loads the result register.
// After reset the slot memory is cleared slot by slot, and no request is
// taken until the clear is done. The queue and result register let each side
// stall on its own.
// ----------------------------------------------------------------------------
module ttl_linear_probe_location_cache_top #(
    parameter int SLOT_COUNT = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], key[65:2], now[97:66], host_in[129:98], port_in[145:130]
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], host_out[33:2], port_out[49:34]
    output logic [55:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [30:0]  cfg_wdata
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int QW = $bits(tlpc_pkg::item_t) + IW;

    logic [30:0]     pos_ttl_reg;
    logic [30:0]     neg_ttl_reg;
    logic            back_ready;
    tlpc_pkg::item_t in_item;
    logic            push;
    logic            full;
    tlpc_pkg::item_t push_item;
    logic [IW-1:0]   push_home;
    logic            q_valid;
    logic            q_pop;
    logic [QW-1:0]   q_data;
    logic [1:0]      out_status;
    logic [31:0]     out_host;
    logic [15:0]     out_port;

    // Unpack the input transfer.
    always_comb begin
        in_item.op   = tlpc_pkg::op_t'(s_tdata[1:0]);
        in_item.key  = s_tdata[65:2];
        in_item.now  = s_tdata[97:66];
        in_item.host = s_tdata[129:98];
        in_item.port = s_tdata[145:130];
    end

    assign m_tdata = {6'd0, out_port, out_host, out_status};

    // Configuration registers; a zero positive TTL is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_ttl_reg <= tlpc_pkg::POS_TTL_RESET;
            neg_ttl_reg <= tlpc_pkg::NEG_TTL_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == tlpc_pkg::CFG_POS_TTL) begin
                if (cfg_wdata != 31'd0) begin
                    pos_ttl_reg <= cfg_wdata;
                end
            end else begin
                neg_ttl_reg <= cfg_wdata;
            end
        end
    end

    tlpc_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (back_ready),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .push      (push),
        .full      (full),
        .push_item (push_item),
        .push_home (push_home)
    );

    tlpc_queue #(.DW(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_item, push_home}),
        .full      (full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    tlpc_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pos_ttl    (pos_ttl_reg),
        .neg_ttl    (neg_ttl_reg),
        .ready      (back_ready),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (tlpc_pkg::item_t'(q_data[QW-1:IW])),
        .q_home     (q_data[IW-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_host   (out_host),
        .out_port   (out_port)
    );

endmodule
